FILE: design/spstq_pkg.sv
// Package for the sorted prefix-sum threshold query block.
// Holds widths, item kinds and the controller/datapath command and status types.
// No dependencies.
package spstq_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 32;
  localparam int SUM_BITS   = 42;
  localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
  localparam int COUNT_BITS = ADDR_BITS + 1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_DROP,
    OP_SEARCH_INIT,
    OP_READ_MID,
    OP_STEP,
    OP_SHIFT_INIT,
    OP_SHIFT_READ,
    OP_SHIFT_WRITE,
    OP_PRE_READ,
    OP_PRE_WRITE,
    OP_SUM_READ,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       search_done;
    logic       shift_done;
    logic       full;
    logic       out_busy;
  } status_t;

endpackage

FILE: design/spstq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spstq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/spstq_dp.sv
// Datapath: sorted value store, prefix-sum store, search bounds and result register.
// Depends on spstq_pkg and spstq_ram.
module spstq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spstq_pkg::cmd_t                      cmd,
  output spstq_pkg::status_t                   status,
  input  logic [1:0]                           kind,
  input  logic [31:0]                          value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [spstq_pkg::SUM_BITS-1:0]       total,
  output logic [spstq_pkg::COUNT_BITS-1:0]     how_many,
  output logic                                 overflowed
);

  localparam int AW = spstq_pkg::ADDR_BITS;
  localparam int CW = spstq_pkg::COUNT_BITS;
  localparam int VW = spstq_pkg::VALUE_BITS;
  localparam int SW = spstq_pkg::SUM_BITS;

  logic [1:0]    kind_r;
  logic [VW-1:0] val_r;
  logic [CW-1:0] lo, hi, idx, fill;
  logic          drop;
  logic [CW-1:0] mid;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [VW-1:0] rd_val, wr_val;
  logic [SW-1:0] rd_sum, wr_sum, base_sum;
  logic [CW-1:0] lo_m1, idx_m1;

  assign mid    = lo + ((hi - lo) >> 1);
  assign lo_m1  = lo - CW'(1);
  assign idx_m1 = idx - CW'(1);
  assign base_sum = (lo == '0) ? '0 : rd_sum;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_val  = rd_val;
    wr_sum  = rd_sum + SW'(val_r);
    case (cmd.op)
      spstq_pkg::OP_READ_MID:  rd_addr = mid[AW-1:0];
      spstq_pkg::OP_SHIFT_READ: rd_addr = idx_m1[AW-1:0];
      spstq_pkg::OP_PRE_READ,
      spstq_pkg::OP_SUM_READ:  rd_addr = lo_m1[AW-1:0];
      spstq_pkg::OP_SHIFT_WRITE: wr_en = 1'b1;
      spstq_pkg::OP_PRE_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = lo[AW-1:0];
        wr_val  = val_r;
        wr_sum  = base_sum + SW'(val_r);
      end
      default: ;
    endcase
  end

  spstq_ram #(.WIDTH(VW), .DEPTH(spstq_pkg::MAX_ITEMS)) u_vals (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_val),
    .rd_addr(rd_addr), .rd_data(rd_val)
  );

  spstq_ram #(.WIDTH(SW), .DEPTH(spstq_pkg::MAX_ITEMS)) u_sums (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_sum),
    .rd_addr(rd_addr), .rd_data(rd_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A new result may be loaded in the same cycle the old one is taken.
      if (cmd.op == spstq_pkg::OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        spstq_pkg::OP_CLEAR: begin
          fill <= '0;
          drop <= 1'b0;
        end
        spstq_pkg::OP_DROP:      drop <= 1'b1;
        spstq_pkg::OP_PRE_WRITE: fill <= fill + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      spstq_pkg::OP_CAPTURE: begin
        kind_r <= kind;
        val_r  <= value[VW-1:0];
      end
      spstq_pkg::OP_SEARCH_INIT: begin
        lo <= '0;
        hi <= fill;
      end
      spstq_pkg::OP_STEP: begin
        if (rd_val > val_r) begin
          hi <= mid;
        end else begin
          lo <= mid + CW'(1);
        end
      end
      spstq_pkg::OP_SHIFT_INIT:  idx <= fill;
      spstq_pkg::OP_SHIFT_WRITE: idx <= idx_m1;
      spstq_pkg::OP_RESULT: begin
        total      <= base_sum;
        how_many   <= lo;
        overflowed <= drop;
      end
      default: ;
    endcase
  end

  assign status.kind        = kind_r;
  assign status.search_done = (lo >= hi);
  assign status.shift_done  = (idx == lo);
  assign status.full        = (fill == CW'(spstq_pkg::MAX_ITEMS));
  assign status.out_busy    = out_valid && !out_ready;

endmodule

FILE: design/spstq_ctrl.sv
// Controller: sequences capture, clear, drop, binary search, insertion shift, prefix write and result.
// Depends on spstq_pkg.
module spstq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spstq_pkg::status_t status,
  output spstq_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE, DISPATCH, S_CHECK, S_WAIT, SH_CHECK, SH_WAIT,
    PRE_WAIT, SUM_WAIT, RESULT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = spstq_pkg::OP_NONE;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.op     = spstq_pkg::OP_CAPTURE;
          state_next = DISPATCH;
        end
      end
      DISPATCH: begin
        case (status.kind)
          spstq_pkg::KIND_CLEAR: begin
            cmd.op     = spstq_pkg::OP_CLEAR;
            state_next = IDLE;
          end
          spstq_pkg::KIND_LOAD: begin
            if (status.full) begin
              cmd.op     = spstq_pkg::OP_DROP;
              state_next = IDLE;
            end else begin
              cmd.op     = spstq_pkg::OP_SEARCH_INIT;
              state_next = S_CHECK;
            end
          end
          spstq_pkg::KIND_QUERY: begin
            cmd.op     = spstq_pkg::OP_SEARCH_INIT;
            state_next = S_CHECK;
          end
          default: state_next = IDLE;
        endcase
      end
      S_CHECK: begin
        if (!status.search_done) begin
          cmd.op     = spstq_pkg::OP_READ_MID;
          state_next = S_WAIT;
        end else if (status.kind == spstq_pkg::KIND_LOAD) begin
          cmd.op     = spstq_pkg::OP_SHIFT_INIT;
          state_next = SH_CHECK;
        end else begin
          cmd.op     = spstq_pkg::OP_SUM_READ;
          state_next = SUM_WAIT;
        end
      end
      S_WAIT: begin
        cmd.op     = spstq_pkg::OP_STEP;
        state_next = S_CHECK;
      end
      SH_CHECK: begin
        if (status.shift_done) begin
          cmd.op     = spstq_pkg::OP_PRE_READ;
          state_next = PRE_WAIT;
        end else begin
          cmd.op     = spstq_pkg::OP_SHIFT_READ;
          state_next = SH_WAIT;
        end
      end
      SH_WAIT: begin
        cmd.op     = spstq_pkg::OP_SHIFT_WRITE;
        state_next = SH_CHECK;
      end
      PRE_WAIT: begin
        cmd.op     = spstq_pkg::OP_PRE_WRITE;
        state_next = IDLE;
      end
      SUM_WAIT: begin
        // Re-issue the prefix read so the data stays valid while waiting.
        cmd.op     = spstq_pkg::OP_SUM_READ;
        state_next = RESULT;
      end
      RESULT: begin
        if (!status.out_busy) begin
          cmd.op     = spstq_pkg::OP_RESULT;
          state_next = IDLE;
        end else begin
          cmd.op     = spstq_pkg::OP_SUM_READ;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/sorted_prefix_sum_threshold_query.sv
// Sorted prefix-sum threshold query, top level. Depends on spstq_pkg, spstq_ctrl, spstq_dp.
// A clear or a dropped load ends at dispatch; a query searches, reads the prefix sum
// and waits while the result register still holds an untaken result; a load searches,
// shifts the larger values up one place and writes the value and its prefix sum.
// One transaction is worked on at a time; each step of the binary search and of the
// insertion shift issues a memory read and then acts on the registered read data.
// Reset clears the fill count, overflow flag and result valid; stores need no clearing.
module sorted_prefix_sum_threshold_query (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         kind,
  input  logic [31:0]                        value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spstq_pkg::SUM_BITS-1:0]     total,
  output logic [spstq_pkg::COUNT_BITS-1:0]   how_many,
  output logic                               overflowed
);

  // Commands go from the controller to the datapath; status comes back.
  spstq_pkg::cmd_t    cmd;
  spstq_pkg::status_t status;

  spstq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .cmd(cmd)
  );

  // The datapath holds the result register, so a finished result can wait
  // for the consumer while the controller takes the next transaction.
  spstq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .kind(kind), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .total(total), .how_many(how_many), .overflowed(overflowed)
  );

  // Input ready always drops right after a transaction is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction was accepted");

  // The count can never exceed the store capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> how_many <= spstq_pkg::COUNT_BITS'(spstq_pkg::MAX_ITEMS))
    else $error("result count beyond capacity");

  // An empty match must report a zero sum.
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && how_many == '0 |-> total == '0)
    else $error("nonzero total with zero count");

endmodule
